// File: rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants of the gap buffer text store: operation codes,
// sequencer states, walk phases, result record and stream field layout.
// ----------------------------------------------------------------------------
package gbts_pkg;

    // Field widths of one input beat and one result beat
    localparam int OP_W        = 3;
    localparam int CHAR_W      = 8;
    localparam int RPOS_W      = 12;
    localparam int POS_W       = 13;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Field offsets inside the result tdata
    localparam int OUT_RD_LSB    = 0;
    localparam int OUT_CUR_LSB   = OUT_RD_LSB + CHAR_W;
    localparam int OUT_LEN_LSB   = OUT_CUR_LSB + POS_W;
    localparam int OUT_REF_BIT   = OUT_LEN_LSB + POS_W;
    localparam int OUT_DIRTY_BIT = OUT_REF_BIT + 1;

    // Line separator byte
    localparam logic [CHAR_W-1:0] LINE_BREAK = 8'h0A;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_LEFT      = 3'd2,
        OP_RIGHT     = 3'd3,
        OP_UP        = 3'd4,
        OP_DOWN      = 3'd5,
        OP_READ      = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_DATA,
        S_SCAN,
        S_SCAN_CHK,
        S_MOVE,
        S_MOVE_WR,
        S_FIN
    } t_state;

    // Steps of an up or down line move
    typedef enum logic [2:0] {
        PH_UP_HERE,
        PH_UP_PREV,
        PH_DN_HERE,
        PH_DN_END,
        PH_DN_NEXT
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [POS_W-1:0]  cursor;
        logic [POS_W-1:0]  text_length;
        logic              insert_refused;
        logic              dirty;
    } t_result;

endpackage

// File: rtl/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Byte text store kept as a gap buffer with the cursor at the gap start.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Left and right move the gap by one byte,
// or leave it as it is at an edge of the text. Up and down scan the store
// one byte at a time through the single read port (back to the line start,
// then over the neighboring line) and then shift the gap one byte at a time;
// an up on the first line or a down on the last line ends right after its
// scans. The byte store needs no clearing after reset. A finished result
// waits in an output register, and the next operation is accepted meanwhile.
// ----------------------------------------------------------------------------
module gap_buffer_text_store
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // operation beats
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // operation[2:0], char_in[10:3], read_position[22:11], zero[23]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // result beats
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // read_char[7:0], cursor[20:8], text_length[33:21], insert_refused[34],
    // dirty[35], zero[39:36]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic              w_res_valid;
    t_result           w_res;
    logic              w_slot_free;
    t_result           w_out;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [CHAR_W-1:0] w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;
    logic [CHAR_W-1:0] w_mem_rdata;

    gbts_ctrl #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_op        (t_op'(i_s_tdata[OP_W-1:0])),
        .i_char      (i_s_tdata[OP_W +: CHAR_W]),
        .i_rpos      (i_s_tdata[OP_W+CHAR_W +: RPOS_W]),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_slot_free),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    gbts_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    gbts_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_res_valid),
        .i_res       (w_res),
        .o_slot_free (w_slot_free),
        .o_valid     (o_m_tvalid),
        .o_res       (w_out),
        .i_ready     (i_m_tready)
    );

    // pack result fields, lowest first
    assign o_m_tdata = {4'b0000, w_out.dirty, w_out.insert_refused,
                        w_out.text_length, w_out.cursor, w_out.read_char};

endmodule

// File: rtl/gbts_mem.sv
// ----------------------------------------------------------------------------
// gbts_mem
// Byte store of the gap buffer: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module gbts_mem
    import gbts_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_store [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_store[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// gbts_ctrl
// Operation sequencer: holds the gap pointers and dirty flag, scans lines
// through the store for up/down and moves bytes across the gap.
// ----------------------------------------------------------------------------
module gbts_ctrl
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096,
    parameter int PW       = 13,
    parameter int AW       = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // operation beat
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_op               i_op,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [RPOS_W-1:0] i_rpos,
    // result handoff
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_ready,
    // store ports
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [CHAR_W-1:0] o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [CHAR_W-1:0] i_mem_rdata
);

    localparam int EW = (PW > RPOS_W) ? PW : RPOS_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [PW-1:0]     r_gf, n_gf;
    logic [PW-1:0]     r_gp, n_gp;
    logic              r_dirty, n_dirty;
    logic [PW-1:0]     r_pos, n_pos;
    logic [PW-1:0]     r_mark, n_mark;
    logic [PW-1:0]     r_col, n_col;
    logic [PW-1:0]     r_target, n_target;
    logic [CHAR_W-1:0] r_rd, n_rd;
    logic              r_refused, n_refused;

    logic              w_accept;
    logic [PW-1:0]     w_len;
    logic [PW-1:0]     w_gap;
    logic              w_back;
    logic [PW-1:0]     w_scan_p;
    logic              w_scan_bound;
    logic              w_lf;
    logic              w_done;
    logic [PW-1:0]     w_phys_in;
    logic [PW-1:0]     w_phys;
    logic              w_in_range;
    logic [PW-1:0]     w_span;
    logic [PW-1:0]     w_base;
    logic              w_left;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_gap    = r_gp - r_gf;
    assign w_len    = CAP_P - w_gap;

    // scan position and termination
    assign w_back = (r_phase == PH_UP_HERE) || (r_phase == PH_UP_PREV) ||
                    (r_phase == PH_DN_HERE);
    assign w_scan_p     = w_back ? (r_pos - 1'b1) : r_pos;
    assign w_scan_bound = w_back ? (r_pos == '0) : (r_pos >= w_len);
    assign w_lf         = (i_mem_rdata == LINE_BREAK);
    assign w_done       = ((r_state == S_SCAN) && w_scan_bound) ||
                          ((r_state == S_SCAN_CHK) && w_lf);

    // logical to physical address, shared by read and scan
    assign w_phys_in  = (r_state == S_IDLE) ? PW'(i_rpos) : w_scan_p;
    assign w_phys     = (w_phys_in < r_gf) ? w_phys_in : (w_phys_in + w_gap);
    assign w_in_range = EW'(i_rpos) < EW'(w_len);

    // target line: length and start for the clipped column
    assign w_span = (r_phase == PH_UP_PREV) ? (r_mark - r_pos) : (r_pos - r_mark);
    assign w_base = (r_phase == PH_UP_PREV) ? r_pos : r_mark;
    assign w_left = (r_target < r_gf);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_LEFT:  n_state = (r_gf != '0) ? S_MOVE : S_FIN;
                        OP_RIGHT: n_state = (r_gp < CAP_P) ? S_MOVE : S_FIN;
                        OP_UP:    n_state = (r_gf != '0) ? S_SCAN : S_FIN;
                        OP_DOWN:  n_state = S_SCAN;
                        OP_READ:  n_state = w_in_range ? S_READ_DATA : S_FIN;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_READ_DATA: n_state = S_FIN;
            S_SCAN, S_SCAN_CHK: begin
                if (w_done) begin
                    unique case (r_phase)
                        PH_UP_HERE: n_state = (r_pos == '0) ? S_FIN : S_SCAN;
                        PH_DN_HERE: n_state = S_SCAN;
                        PH_DN_END:  n_state = (r_pos >= w_len) ? S_FIN : S_SCAN;
                        default:    n_state = S_MOVE;
                    endcase
                end else begin
                    n_state = (r_state == S_SCAN) ? S_SCAN_CHK : S_SCAN;
                end
            end
            S_MOVE:    n_state = (r_gf == r_target) ? S_FIN : S_MOVE_WR;
            S_MOVE_WR: n_state = S_MOVE;
            S_FIN:     n_state = i_res_ready ? S_IDLE : S_FIN;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and store accesses
    always_comb begin
        n_phase     = r_phase;
        n_gf        = r_gf;
        n_gp        = r_gp;
        n_dirty     = r_dirty;
        n_pos       = r_pos;
        n_mark      = r_mark;
        n_col       = r_col;
        n_target    = r_target;
        n_rd        = r_rd;
        n_refused   = r_refused;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_gf[AW-1:0];
        o_mem_wdata = i_char;
        o_mem_raddr = w_phys[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rd      = '0;
                    n_refused = 1'b0;
                    n_pos     = r_gf;
                    unique case (i_op)
                        OP_INSERT: begin
                            if (r_gf >= r_gp) begin
                                n_refused = 1'b1;
                            end else begin
                                o_mem_we = 1'b1;
                                n_gf     = r_gf + 1'b1;
                                n_dirty  = 1'b1;
                            end
                        end
                        OP_BACKSPACE: begin
                            if (r_gf != '0) begin
                                n_gf    = r_gf - 1'b1;
                                n_dirty = 1'b1;
                            end
                        end
                        OP_LEFT:  n_target = r_gf - 1'b1;
                        OP_RIGHT: n_target = r_gf + 1'b1;
                        OP_UP:    n_phase  = PH_UP_HERE;
                        OP_DOWN:  n_phase  = PH_DN_HERE;
                        default: ;
                    endcase
                end
            end
            S_READ_DATA: n_rd = i_mem_rdata;
            S_SCAN, S_SCAN_CHK: begin
                if (w_done) begin
                    unique case (r_phase)
                        PH_UP_HERE: begin
                            n_col   = r_gf - r_pos;
                            n_pos   = r_pos - 1'b1;
                            n_mark  = r_pos - 1'b1;
                            n_phase = PH_UP_PREV;
                        end
                        PH_DN_HERE: begin
                            n_col   = r_gf - r_pos;
                            n_pos   = r_gf;
                            n_phase = PH_DN_END;
                        end
                        PH_DN_END: begin
                            n_pos   = r_pos + 1'b1;
                            n_mark  = r_pos + 1'b1;
                            n_phase = PH_DN_NEXT;
                        end
                        default: begin
                            n_target = w_base + ((r_col < w_span) ? r_col : w_span);
                        end
                    endcase
                end else if (r_state == S_SCAN_CHK) begin
                    n_pos = w_back ? (r_pos - 1'b1) : (r_pos + 1'b1);
                end
            end
            S_MOVE: begin
                o_mem_raddr = w_left ? AW'(r_gf - 1'b1) : AW'(r_gp);
            end
            S_MOVE_WR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                if (w_left) begin
                    o_mem_waddr = AW'(r_gp - 1'b1);
                    n_gf        = r_gf - 1'b1;
                    n_gp        = r_gp - 1'b1;
                end else begin
                    o_mem_waddr = AW'(r_gf);
                    n_gf        = r_gf + 1'b1;
                    n_gp        = r_gp + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gf    <= '0;
            r_gp    <= CAP_P;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gf    <= n_gf;
            r_gp    <= n_gp;
            r_dirty <= n_dirty;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_pos     <= n_pos;
        r_mark    <= n_mark;
        r_col     <= n_col;
        r_target  <= n_target;
        r_rd      <= n_rd;
        r_refused <= n_refused;
    end

    // handshake and result
    assign o_in_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    always_comb begin
        o_res.read_char      = r_rd;
        o_res.cursor         = POS_W'(r_gf);
        o_res.text_length    = POS_W'(w_len);
        o_res.insert_refused = r_refused;
        o_res.dirty          = r_dirty;
    end

endmodule

// File: rtl/gbts_obuf.sv
// ----------------------------------------------------------------------------
// gbts_obuf
// Result holding register: keeps a finished result until the sink takes it,
// so the sequencer can go on with the next operation.
// ----------------------------------------------------------------------------
module gbts_obuf
    import gbts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_slot_free,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_slot_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/gbts_checker.sv
// ----------------------------------------------------------------------------
// gbts_checker
// Port-level checks on the result stream of the gap buffer text store.
// ----------------------------------------------------------------------------
module gbts_checker
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic [POS_W-1:0] w_cur;
    logic [POS_W-1:0] w_len;
    logic             w_ref;
    logic             w_dirty;

    assign w_cur   = o_m_tdata[OUT_CUR_LSB +: POS_W];
    assign w_len   = o_m_tdata[OUT_LEN_LSB +: POS_W];
    assign w_ref   = o_m_tdata[OUT_REF_BIT];
    assign w_dirty = o_m_tdata[OUT_DIRTY_BIT];

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // cursor never passes the end of the text (checked for CAPACITY below 8192)
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (CAPACITY >= 8192) || (w_cur <= w_len))
        else $error("cursor beyond text length");

    // a refused insert only happens on a full store
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_ref |-> w_len == POS_W'(CAPACITY))
        else $error("insert refused with room left");

    // dirty never clears between results
    a_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && $past(o_m_tvalid) && $past(o_m_tdata[OUT_DIRTY_BIT]) |-> w_dirty)
        else $error("dirty flag cleared");

endmodule

bind gap_buffer_text_store gbts_checker #(.CAPACITY(CAPACITY)) u_gbts_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gap buffer text store. Operation beats are
// driven on the input stream; every result beat is checked field by field
// against an in-bench gap buffer that mirrors the text, the gap, the cursor
// and the modified flag. Covers edge moves on empty text, line moves with
// column clipping, random editing under source and sink idling, a long
// output stall and a completely full store.
// ----------------------------------------------------------------------------
module testbench;
    import gbts_pkg::*;

    localparam int unsigned CAP           = 4096;
    localparam int          STALL_LIMIT   = 50000;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 400;
    // Code with no operation behind it
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // operation[2:0], char_in[10:3], read_position[22:11], zero[23]
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // read_char[7:0], cursor[20:8], text_length[33:21], insert_refused[34],
    // dirty[35], zero[39:36]
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    gap_buffer_text_store #(
        .CAPACITY (CAP)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Mirror of the text store
    logic [CHAR_W-1:0] mirror [CAP];
    int unsigned       gap_lo;
    int unsigned       gap_hi;
    bit                edited;

    t_result pending_results [$];
    int      src_idle_pct;
    int      sink_idle_pct;
    int      hold_left;
    int      idle_cycles;
    int      error_count;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Gap buffer mirror
    // ------------------------------------------------------------------
    function automatic int unsigned stored_len();
        return CAP - (gap_hi - gap_lo);
    endfunction

    function automatic logic [CHAR_W-1:0] char_at(int unsigned pos);
        int unsigned idx;
        idx = (pos < gap_lo) ? pos : pos + (gap_hi - gap_lo);
        return (idx >= CAP) ? '0 : mirror[idx];
    endfunction

    function automatic void shift_left();
        if (gap_lo != 0) begin
            gap_lo--;
            gap_hi--;
            mirror[gap_hi] = mirror[gap_lo];
        end
    endfunction

    function automatic void shift_right();
        if (gap_hi < CAP) begin
            mirror[gap_lo] = mirror[gap_hi];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    function automatic int unsigned line_head(int unsigned pos);
        while (pos > 0 && char_at(pos - 1) != LINE_BREAK)
            pos--;
        return pos;
    endfunction

    function automatic int unsigned line_tail(int unsigned pos);
        int unsigned n;
        n = stored_len();
        while (pos < n && char_at(pos) != LINE_BREAK)
            pos++;
        return pos;
    endfunction

    function automatic void seek(int unsigned target);
        while (gap_lo > target)
            shift_left();
        while (gap_lo < target && gap_hi < CAP)
            shift_right();
    endfunction

    // Column is kept, clipped to the target line length
    function automatic void cursor_up();
        int unsigned here, col, above_end, above_start, above_len;
        if (gap_lo != 0) begin
            here = line_head(gap_lo);
            if (here != 0) begin
                col         = gap_lo - here;
                above_end   = here - 1;
                above_start = line_head(above_end);
                above_len   = above_end - above_start;
                seek(above_start + ((col < above_len) ? col : above_len));
            end
        end
    endfunction

    function automatic void cursor_down();
        int unsigned here, col, cur_end, below_start, below_len;
        here    = line_head(gap_lo);
        col     = gap_lo - here;
        cur_end = line_tail(gap_lo);
        if (cur_end < stored_len()) begin
            below_start = cur_end + 1;
            below_len   = line_tail(below_start) - below_start;
            seek(below_start + ((col < below_len) ? col : below_len));
        end
    endfunction

    // Applies one operation to the mirror and returns the result beat
    function automatic t_result predict_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                             logic [RPOS_W-1:0] rpos);
        t_result res;
        res = '0;
        case (op)
            OP_INSERT: begin
                if (gap_lo >= gap_hi) begin
                    res.insert_refused = 1'b1;
                end else begin
                    mirror[gap_lo] = ch;
                    gap_lo++;
                    edited = 1'b1;
                end
            end
            OP_BACKSPACE: begin
                if (gap_lo > 0) begin
                    gap_lo--;
                    edited = 1'b1;
                end
            end
            OP_LEFT:  shift_left();
            OP_RIGHT: shift_right();
            OP_UP:    cursor_up();
            OP_DOWN:  cursor_down();
            OP_READ: begin
                if (rpos < stored_len())
                    res.read_char = char_at(rpos);
            end
            default: ;
        endcase
        res.cursor      = POS_W'(gap_lo);
        res.text_length = POS_W'(stored_len());
        res.dirty       = edited;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one operation beat
    // ------------------------------------------------------------------
    task automatic send_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [RPOS_W-1:0] rpos);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata  = {1'b0, rpos, ch, op};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_edit(op, ch, rpos));
    endtask

    // Random operation, weighted to keep the text short
    task automatic send_random_edit();
        int unsigned      len;
        int               pick;
        int               ins_w;
        logic [CHAR_W-1:0] ch;
        logic [RPOS_W-1:0] rpos;
        len   = stored_len();
        pick  = $urandom_range(99);
        ins_w = (len > 250) ? 15 : 38;
        ch    = ($urandom_range(4) == 0) ? LINE_BREAK : CHAR_W'($urandom_range(255));
        if (len == 0 || $urandom_range(9) < 3)
            rpos = RPOS_W'($urandom_range(4095));
        else if ($urandom_range(9) == 0)
            rpos = RPOS_W'(len);
        else
            rpos = RPOS_W'($urandom_range(len - 1));
        if (pick < ins_w)
            send_edit(OP_INSERT, ch, rpos);
        else if (pick < 55)
            send_edit(OP_BACKSPACE, ch, rpos);
        else if (pick < 64)
            send_edit(OP_LEFT, ch, rpos);
        else if (pick < 73)
            send_edit(OP_RIGHT, ch, rpos);
        else if (pick < 80)
            send_edit(OP_UP, ch, rpos);
        else if (pick < 87)
            send_edit(OP_DOWN, ch, rpos);
        else if (pick < 98)
            send_edit(OP_READ, ch, rpos);
        else
            send_edit(OP_UNUSED, ch, rpos);
    endtask

    // ------------------------------------------------------------------
    // Output side: sink readiness, with an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_tready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result check and stall count
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no operation pending");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("read_char", want.read_char,
                                o_m_tdata[OUT_RD_LSB +: CHAR_W]);
                    check_field("cursor", want.cursor, o_m_tdata[OUT_CUR_LSB +: POS_W]);
                    check_field("text_length", want.text_length,
                                o_m_tdata[OUT_LEN_LSB +: POS_W]);
                    check_field("insert_refused", want.insert_refused,
                                o_m_tdata[OUT_REF_BIT]);
                    check_field("dirty", want.dirty, o_m_tdata[OUT_DIRTY_BIT]);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty-text edges, field extremes, every operation, column clipping
    task automatic test_directed_edges();
        send_edit(OP_BACKSPACE, 8'h00, 12'd0);
        send_edit(OP_LEFT, 8'h00, 12'd0);
        send_edit(OP_RIGHT, 8'h00, 12'd0);
        send_edit(OP_UP, 8'h00, 12'd0);
        send_edit(OP_DOWN, 8'h00, 12'd0);
        send_edit(OP_READ, 8'h00, 12'd0);
        send_edit(OP_UNUSED, 8'hFF, 12'hFFF);
        // text: 00 FF \n a b c
        send_edit(OP_INSERT, 8'h00, 12'd0);
        send_edit(OP_INSERT, 8'hFF, 12'hFFF);
        send_edit(OP_INSERT, LINE_BREAK, 12'd0);
        send_edit(OP_INSERT, "a", 12'd0);
        send_edit(OP_INSERT, "b", 12'd0);
        send_edit(OP_INSERT, "c", 12'd0);
        // column 3 clipped to the 2-byte first line, then back down
        send_edit(OP_UP, 8'h00, 12'd0);
        send_edit(OP_DOWN, 8'h00, 12'd0);
        send_edit(OP_RIGHT, 8'h00, 12'd0);
        // down on the last line
        send_edit(OP_DOWN, 8'h00, 12'd0);
        send_edit(OP_INSERT, LINE_BREAK, 12'd0);
        send_edit(OP_INSERT, "x", 12'd0);
        send_edit(OP_UP, 8'h00, 12'd0);
        send_edit(OP_READ, 8'h00, 12'd1);
        send_edit(OP_READ, 8'h00, 12'd8);
        // backspace in mid text, then one step right
        send_edit(OP_LEFT, 8'h00, 12'd0);
        send_edit(OP_BACKSPACE, 8'h00, 12'd0);
        send_edit(OP_RIGHT, 8'h00, 12'd0);
    endtask

    task automatic test_random_edits(input int count, input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
            send_random_edit();
    endtask

    // Sink holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        repeat (40)
            send_random_edit();
    endtask

    // Fill to capacity, refused inserts, edits and reads on a full store
    task automatic test_store_full();
        logic [CHAR_W-1:0] ch;
        repeat (10)
            send_edit(OP_LEFT, 8'h00, 12'd0);
        while (stored_len() < CAP) begin
            ch = ($urandom_range(39) == 0) ? LINE_BREAK : CHAR_W'($urandom_range(255));
            send_edit(OP_INSERT, ch, RPOS_W'($urandom_range(4095)));
        end
        send_edit(OP_INSERT, 8'h00, 12'd0);
        send_edit(OP_INSERT, 8'hFF, 12'hFFF);
        send_edit(OP_READ, 8'h00, 12'hFFF);
        send_edit(OP_READ, 8'h00, 12'd0);
        repeat (4)
            send_edit(OP_READ, 8'h00, RPOS_W'($urandom_range(4095)));
        send_edit(OP_UP, 8'h00, 12'd0);
        send_edit(OP_DOWN, 8'h00, 12'd0);
        send_edit(OP_UP, 8'h00, 12'd0);
        repeat (12)
            send_edit(OP_RIGHT, 8'h00, 12'd0);
        send_edit(OP_DOWN, 8'h00, 12'd0);
        send_edit(OP_BACKSPACE, 8'h00, 12'd0);
        send_edit(OP_INSERT, LINE_BREAK, 12'd0);
        send_edit(OP_INSERT, 8'h5A, 12'd0);
        send_edit(OP_READ, 8'h00, 12'hFFF);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        src_idle_pct  = 22;
        sink_idle_pct = 57;
        hold_left     = 0;
        idle_cycles   = 0;
        error_count   = 0;
        gap_lo        = 0;
        gap_hi        = CAP;
        edited        = 1'b0;
        foreach (mirror[i])
            mirror[i] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_random_edits(600, 22, 57);
        test_random_edits(600, 57, 22);
        test_output_backpressure();
        test_random_edits(600, 0, 0);
        test_store_full();

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
